// File: rtl/sseq_pkg.sv
// shared types and constants for the single-server event queue step block
// no dependencies; imported by sseq_cell and single_server_event_queue_step
package sseq_pkg;

    // event kinds held in the store and reported per transaction
    localparam logic KIND_ARR = 1'b1;
    localparam logic KIND_DEP = 1'b0;

    // request codes on req_type
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_OVF   = 2'd2;

    // reset value of the finish limit register
    localparam logic [15:0] FINISH_RESET = 16'd10000;

    // saturation limits of the statistics
    localparam logic [47:0] ACC_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // command applied to every cell of the sorted chain
    typedef enum logic [1:0] {
        CELL_NOP,
        CELL_CLEAR,
        CELL_POP,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     kind;
    } cell_ctl_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INS_A,
        ST_INS_B,
        ST_RESULT
    } seq_state_t;

endpackage

// File: rtl/sseq_cell.sv
// one slot of the time-sorted event chain: holds kind and time of one event
// depends on sseq_pkg for the cell command struct
module sseq_cell #(
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sseq_pkg::cell_ctl_t  ctl,
    input  logic [TIME_BITS-1:0] ins_time,
    input  logic                 left_stays,
    input  logic                 left_valid,
    input  logic                 left_kind,
    input  logic [TIME_BITS-1:0] left_time,
    input  logic                 right_valid,
    input  logic                 right_kind,
    input  logic [TIME_BITS-1:0] right_time,
    output logic                 valid,
    output logic                 kind,
    output logic [TIME_BITS-1:0] evt_time,
    output logic                 stays
);
    import sseq_pkg::*;

    logic                 valid_reg;
    logic                 kind_reg;
    logic [TIME_BITS-1:0] time_reg;

    // entry keeps its place on insert when it is not later than the new event
    assign stays    = valid_reg && (time_reg <= ins_time);
    assign valid    = valid_reg;
    assign kind     = kind_reg;
    assign evt_time = time_reg;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            unique case (ctl.op)
                CELL_NOP:
                begin
                    valid_reg <= valid_reg;
                end
                CELL_CLEAR:
                begin
                    valid_reg <= 1'b0;
                end
                CELL_POP:
                begin
                    valid_reg <= right_valid;
                end
                CELL_INSERT:
                begin
                    if (!stays)
                    begin
                        valid_reg <= left_stays ? 1'b1 : left_valid;
                    end
                end
            endcase
        end
    end

    // payload: shift toward head on pop, open a gap on insert
    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            CELL_NOP, CELL_CLEAR:
            begin
                kind_reg <= kind_reg;
            end
            CELL_POP:
            begin
                kind_reg <= right_kind;
                time_reg <= right_time;
            end
            CELL_INSERT:
            begin
                if (!stays)
                begin
                    if (left_stays)
                    begin
                        kind_reg <= ctl.kind;
                        time_reg <= ins_time;
                    end
                    else
                    begin
                        kind_reg <= left_kind;
                        time_reg <= left_time;
                    end
                end
            end
        endcase
    end

endmodule

// File: rtl/single_server_event_queue_step.sv
// top level of the single-server queue step engine with its sorted event chain
// depends on sseq_pkg and sseq_cell
//
//  channel  handshake             payload
//  in       in_valid / in_stall   req_type, gap_draw, service_draw
//  out      out_valid / out_stall event_kind .. status (one result per transaction)
//  cfg      cfg_wr_en             cfg_wr_data (finish limit)
//
// A transaction passes through the accept cycle, the pop and statistics update, the
// insert states ST_INS_A and ST_INS_B on the cell chain and the result register load.
// The result is valid from that load on; the next transaction is accepted back in
// idle. The insert states are set by the chain taking one event a cycle.
// Reset empties the chain and clears all statistics; the finish limit returns to 10000.
// A new transaction is accepted while the previous result still waits; it holds
// before the result load until the output register is free.
module single_server_event_queue_step #(
    parameter int EVENT_SLOTS = 4,
    parameter int TIME_BITS   = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] gap_draw,
    input  logic [31:0] service_draw,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        event_kind,
    output logic [47:0] event_time,
    output logic [15:0] ready_count,
    output logic [15:0] finished_count,
    output logic [47:0] idle_total,
    output logic [47:0] waiting_sum,
    output logic        server_free,
    output logic        done_res,
    output logic [1:0]  status,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import sseq_pkg::*;

    localparam int SUM_W = ((TIME_BITS > 48) ? TIME_BITS : 48) + 1;

    seq_state_t state_reg, state_next;

    // latched request
    logic                 req_reg;
    logic [31:0]          gap_reg;
    logic [31:0]          serv_reg;

    // simulation state
    logic [15:0]          limit_reg;
    logic [TIME_BITS-1:0] clock_reg;
    logic                 srv_idle_reg;
    logic [15:0]          waiting_reg;
    logic [15:0]          completed_reg;
    logic [47:0]          idle_reg;
    logic [47:0]          wait_reg;

    // per-transaction work registers
    logic                 kind_reg;
    logic [1:0]           status_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic                 acc_idle_reg;
    logic                 ins_a_vld_reg;
    logic                 ins_a_kind_reg;
    logic [TIME_BITS-1:0] ins_a_time_reg;
    logic                 ins_b_vld_reg;
    logic                 ins_b_kind_reg;
    logic [TIME_BITS-1:0] ins_b_time_reg;

    // result register
    logic                 out_valid_reg;
    logic                 res_kind_reg;
    logic [47:0]          res_time_reg;
    logic [15:0]          res_ready_reg;
    logic [15:0]          res_fin_reg;
    logic [47:0]          res_idle_reg;
    logic [47:0]          res_wait_reg;
    logic                 res_free_reg;
    logic                 res_done_reg;
    logic [1:0]           res_status_reg;

    // chain signals
    cell_ctl_t            cell_ctl;
    logic [TIME_BITS-1:0] cell_ins_time;
    logic                 c_valid [EVENT_SLOTS];
    logic                 c_kind  [EVENT_SLOTS];
    logic [TIME_BITS-1:0] c_time  [EVENT_SLOTS];
    logic                 c_stays [EVENT_SLOTS];

    logic                 chain_full;
    logic                 chain_empty;
    logic [TIME_BITS-1:0] head_time;
    logic                 head_kind;
    logic [TIME_BITS:0]   head_plus_serv;
    logic [TIME_BITS:0]   head_plus_gap;
    logic [TIME_BITS-1:0] dep_time;
    logic [TIME_BITS-1:0] arr_time;
    logic [SUM_W-1:0]     idle_sum;
    logic [48:0]          wait_sum;
    logic                 res_load;
    logic                 ins_active;
    logic                 ins_kind;
    logic [TIME_BITS-1:0] ins_time;

    assign in_stall    = (state_reg != ST_IDLE);
    assign chain_full  = c_valid[EVENT_SLOTS-1];
    assign chain_empty = !c_valid[0];
    assign head_time   = c_time[0];
    assign head_kind   = c_kind[0];

    // saturating event times from the head time
    assign head_plus_serv = {1'b0, head_time} + (TIME_BITS+1)'(serv_reg);
    assign head_plus_gap  = {1'b0, head_time} + (TIME_BITS+1)'(gap_reg);
    assign dep_time = head_plus_serv[TIME_BITS] ? {TIME_BITS{1'b1}}
                                                : head_plus_serv[TIME_BITS-1:0];
    assign arr_time = head_plus_gap[TIME_BITS] ? {TIME_BITS{1'b1}}
                                               : head_plus_gap[TIME_BITS-1:0];

    // statistic sums before saturation
    assign idle_sum = SUM_W'(idle_reg) + SUM_W'(elapsed_reg);
    assign wait_sum = {1'b0, wait_reg} + 49'(waiting_reg);

    // sorted event chain
    for (genvar i = 0; i < EVENT_SLOTS; i++)
    begin : g_cell
        logic                 l_stays;
        logic                 l_valid;
        logic                 l_kind;
        logic [TIME_BITS-1:0] l_time;
        logic                 r_valid;
        logic                 r_kind;
        logic [TIME_BITS-1:0] r_time;

        if (i == 0)
        begin : g_head
            assign l_stays = 1'b1;
            assign l_valid = 1'b0;
            assign l_kind  = KIND_DEP;
            assign l_time  = '0;
        end
        else
        begin : g_body
            assign l_stays = c_stays[i-1];
            assign l_valid = c_valid[i-1];
            assign l_kind  = c_kind[i-1];
            assign l_time  = c_time[i-1];
        end

        if (i == EVENT_SLOTS-1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_kind  = KIND_DEP;
            assign r_time  = '0;
        end
        else
        begin : g_inner
            assign r_valid = c_valid[i+1];
            assign r_kind  = c_kind[i+1];
            assign r_time  = c_time[i+1];
        end

        sseq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl),
            .ins_time    (cell_ins_time),
            .left_stays  (l_stays),
            .left_valid  (l_valid),
            .left_kind   (l_kind),
            .left_time   (l_time),
            .right_valid (r_valid),
            .right_kind  (r_kind),
            .right_time  (r_time),
            .valid       (c_valid[i]),
            .kind        (c_kind[i]),
            .evt_time    (c_time[i]),
            .stays       (c_stays[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:   state_next = ST_INS_A;
            ST_INS_A:  state_next = ST_INS_B;
            ST_INS_B:  state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // chain command and strobes per state
    always_comb
    begin
        cell_ctl      = '{op: CELL_NOP, kind: KIND_DEP};
        cell_ins_time = ins_a_time_reg;
        ins_active    = 1'b0;
        ins_kind      = ins_a_kind_reg;
        ins_time      = ins_a_time_reg;
        res_load      = 1'b0;
        unique case (state_reg)
            ST_EXEC:
            begin
                if (req_reg == REQ_START)
                begin
                    cell_ctl.op = CELL_CLEAR;
                end
                else if (!chain_empty)
                begin
                    cell_ctl.op = CELL_POP;
                end
            end
            ST_INS_A:
            begin
                ins_active = ins_a_vld_reg;
            end
            ST_INS_B:
            begin
                ins_active = ins_b_vld_reg;
                ins_kind   = ins_b_kind_reg;
                ins_time   = ins_b_time_reg;
            end
            ST_RESULT:
            begin
                res_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                cell_ctl.op = CELL_NOP;
            end
        endcase
        if (ins_active && !chain_full)
        begin
            cell_ctl.op   = CELL_INSERT;
            cell_ctl.kind = ins_kind;
            cell_ins_time = ins_time;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            limit_reg     <= FINISH_RESET;
            clock_reg     <= '0;
            srv_idle_reg  <= 1'b1;
            waiting_reg   <= '0;
            completed_reg <= '0;
            idle_reg      <= '0;
            wait_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // output transaction handshake
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // finish limit register
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end

            // start clears, step pops and updates statistics
            if (state_reg == ST_EXEC)
            begin
                if (req_reg == REQ_START)
                begin
                    clock_reg     <= '0;
                    srv_idle_reg  <= 1'b1;
                    waiting_reg   <= '0;
                    completed_reg <= '0;
                    idle_reg      <= '0;
                    wait_reg      <= '0;
                end
                else if (!chain_empty)
                begin
                    clock_reg <= head_time;
                    wait_reg  <= wait_sum[48] ? ACC_MAX : wait_sum[47:0];
                    if (head_kind == KIND_ARR)
                    begin
                        if (srv_idle_reg)
                        begin
                            srv_idle_reg <= 1'b0;
                        end
                        else if (waiting_reg != CNT_MAX)
                        begin
                            waiting_reg <= waiting_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        if (waiting_reg == '0)
                        begin
                            srv_idle_reg <= 1'b1;
                        end
                        else
                        begin
                            waiting_reg <= waiting_reg - 16'd1;
                        end
                        if (completed_reg != CNT_MAX)
                        begin
                            completed_reg <= completed_reg + 16'd1;
                        end
                    end
                end
            end

            // idle time accumulation in the cycle after the pop
            if (state_reg == ST_INS_A && acc_idle_reg)
            begin
                idle_reg <= (idle_sum > SUM_W'(ACC_MAX)) ? ACC_MAX : idle_sum[47:0];
            end
        end
    end

    // work and payload registers
    always_ff @(posedge clk)
    begin
        // latch the input transaction
        if (state_reg == ST_IDLE && in_valid)
        begin
            req_reg  <= req_type;
            gap_reg  <= gap_draw;
            serv_reg <= service_draw;
        end

        // plan the inserts of this transaction
        if (state_reg == ST_EXEC)
        begin
            acc_idle_reg  <= 1'b0;
            ins_a_vld_reg <= 1'b0;
            ins_b_vld_reg <= 1'b0;
            status_reg    <= STAT_OK;
            if (req_reg == REQ_START)
            begin
                kind_reg       <= KIND_ARR;
                ins_a_vld_reg  <= 1'b1;
                ins_a_kind_reg <= KIND_ARR;
                ins_a_time_reg <= TIME_BITS'(gap_reg);
            end
            else if (chain_empty)
            begin
                kind_reg   <= KIND_DEP;
                status_reg <= STAT_EMPTY;
            end
            else
            begin
                kind_reg     <= head_kind;
                acc_idle_reg <= srv_idle_reg;
                elapsed_reg  <= (head_time > clock_reg) ? head_time - clock_reg : '0;
                if (head_kind == KIND_ARR)
                begin
                    ins_a_vld_reg <= 1'b1;
                    if (srv_idle_reg)
                    begin
                        ins_a_kind_reg <= KIND_DEP;
                        ins_a_time_reg <= dep_time;
                        ins_b_vld_reg  <= 1'b1;
                        ins_b_kind_reg <= KIND_ARR;
                        ins_b_time_reg <= arr_time;
                    end
                    else
                    begin
                        ins_a_kind_reg <= KIND_ARR;
                        ins_a_time_reg <= arr_time;
                    end
                end
                else if (waiting_reg != '0)
                begin
                    ins_a_vld_reg  <= 1'b1;
                    ins_a_kind_reg <= KIND_DEP;
                    ins_a_time_reg <= dep_time;
                end
            end
        end

        // dropped insert on a full chain
        if (ins_active && chain_full)
        begin
            status_reg <= STAT_OVF;
        end

        // result snapshot
        if (res_load)
        begin
            res_kind_reg   <= kind_reg;
            res_time_reg   <= 48'(clock_reg);
            res_ready_reg  <= waiting_reg;
            res_fin_reg    <= completed_reg;
            res_idle_reg   <= idle_reg;
            res_wait_reg   <= wait_reg;
            res_free_reg   <= srv_idle_reg;
            res_done_reg   <= (completed_reg >= limit_reg);
            res_status_reg <= status_reg;
        end
    end

    // result ports
    assign out_valid      = out_valid_reg;
    assign event_kind     = res_kind_reg;
    assign event_time     = res_time_reg;
    assign ready_count    = res_ready_reg;
    assign finished_count = res_fin_reg;
    assign idle_total     = res_idle_reg;
    assign waiting_sum    = res_wait_reg;
    assign server_free    = res_free_reg;
    assign done_res       = res_done_reg;
    assign status         = res_status_reg;

endmodule
